[rtl/core/maccc_pkg.sv]
// ----------------------------------------------------------------------------
// maccc_pkg: shared constants for the multi-alphabet Caesar cipher core
// Character codes, alphabet sizes, the sign table, register map and the
// key reduction helpers.
// ----------------------------------------------------------------------------
package maccc_pkg;

    localparam int CHAR_W   = 16;
    localparam int KEY_W    = 6;
    localparam int POS_W    = 6;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 16'h0020;

    // Alphabet sizes
    localparam logic [POS_W-1:0] EN_LEN   = 6'd26;
    localparam logic [POS_W-1:0] RU_LEN   = 6'd33;
    localparam logic [POS_W-1:0] SIGN_LEN = 6'd30;
    localparam logic [POS_W-1:0] DIG_LEN  = 6'd10;

    // Contiguous ranges
    localparam logic [CHAR_W-1:0] EN_UPPER_BASE = 16'h0041;
    localparam logic [CHAR_W-1:0] EN_LOWER_BASE = 16'h0061;
    localparam logic [CHAR_W-1:0] DIG_BASE      = 16'h0030;

    // Cyrillic: 32 contiguous letters with YO spliced in after YE
    localparam logic [CHAR_W-1:0] RU_UPPER_BASE = 16'h0410;
    localparam logic [CHAR_W-1:0] RU_UPPER_YO   = 16'h0401;
    localparam logic [CHAR_W-1:0] RU_LOWER_BASE = 16'h0430;
    localparam logic [CHAR_W-1:0] RU_LOWER_YO   = 16'h0451;
    localparam logic [POS_W-1:0]  RU_YO_POS     = 6'd6;
    localparam logic [CHAR_W-1:0] RU_SPAN       = 16'd32;

    localparam int SIGN_COUNT = 30;
    localparam int SIGN_IDX_W = $clog2(SIGN_COUNT);

    localparam logic [CHAR_W-1:0] SIGN_TABLE [SIGN_COUNT] = '{
        16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h005E, 16'h0026,
        16'h002A, 16'h0028, 16'h0029, 16'h002B, 16'h003D, 16'h002D, 16'h005F,
        16'h0027, 16'h003F, 16'h002E, 16'h002C, 16'h007C, 16'h002F, 16'h0060,
        16'h007E, 16'h2116, 16'h003A, 16'h003B, 16'h0040, 16'h005B, 16'h005D,
        16'h007B, 16'h007D
    };

    // Register map: index is address bit 2
    localparam logic REG_IDX_SHIFT_KEY = 1'b0;
    localparam logic REG_IDX_DIRECTION = 1'b1;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    // Reduce a 6-bit key modulo an alphabet size of at least 10.
    function automatic logic [POS_W-1:0] reduce_key(input logic [KEY_W-1:0] key,
                                                    input logic [POS_W-1:0] len);
        logic [POS_W-1:0] r;
        r = key;
        for (int i = 0; i < 6; i++) begin
            if (r >= len) begin
                r = r - len;
            end
        end
        return r;
    endfunction

    // Forward step in 0..len-1 that realizes the shift in either direction.
    function automatic logic [POS_W-1:0] fwd_amount(input logic [KEY_W-1:0] key,
                                                    input logic [POS_W-1:0] len,
                                                    input logic             dir);
        logic [POS_W-1:0] k;
        k = reduce_key(key, len);
        if (dir == DIR_DECRYPT && k != '0) begin
            return len - k;
        end
        return k;
    endfunction

endpackage

[rtl/core/multi_alphabet_caesar_cipher_core.sv]
// ----------------------------------------------------------------------------
// multi_alphabet_caesar_cipher_core: per-character Caesar shift over six alphabets
// An input transaction passes the input register and then the result register
// before the earliest output transaction; a stalled output holds it back.
// Throughput: one character per cycle while out_stall is low; set by the single
// lookup/add/wrap path between the input register and the result register.
// Characters in no alphabet are dropped and produce no output transaction.
// Reset (rst_n low, asynchronous) empties both stages, clears shift_key to 0
// and direction to encrypt.
// ----------------------------------------------------------------------------
module multi_alphabet_caesar_cipher_core (
    input  logic                             clk,
    input  logic                             rst_n,

    // APB-style configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [maccc_pkg::ADDR_W-1:0]     paddr,
    input  logic [maccc_pkg::DATA_W-1:0]     pwdata,
    output logic [maccc_pkg::DATA_W-1:0]     prdata,
    output logic                             pready,

    // Input character channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [maccc_pkg::CHAR_W-1:0]     char_in,

    // Output character channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [maccc_pkg::CHAR_W-1:0]     char_out
);

    // Which alphabet the held character belongs to
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_SPACE,
        CLS_EN_UPPER,
        CLS_EN_LOWER,
        CLS_RU_UPPER,
        CLS_RU_LOWER,
        CLS_SIGN,
        CLS_DIGIT
    } char_class_t;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [maccc_pkg::KEY_W-1:0] shift_key_reg;
    logic                        direction_reg;
    logic                        cfg_write;

    // Forward step per alphabet size, loaded with every register write so the
    // character path only adds and wraps.
    logic [maccc_pkg::POS_W-1:0] fwd_en_reg;
    logic [maccc_pkg::POS_W-1:0] fwd_ru_reg;
    logic [maccc_pkg::POS_W-1:0] fwd_sign_reg;
    logic [maccc_pkg::POS_W-1:0] fwd_dig_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shift_key_reg <= '0;
            direction_reg <= maccc_pkg::DIR_ENCRYPT;
            fwd_en_reg    <= '0;
            fwd_ru_reg    <= '0;
            fwd_sign_reg  <= '0;
            fwd_dig_reg   <= '0;
        end
        else if (cfg_write) begin
            // Keep only the bits the register is wide; low address bits alias
            if (paddr[2] == maccc_pkg::REG_IDX_SHIFT_KEY) begin
                shift_key_reg <= pwdata[maccc_pkg::KEY_W-1:0];
                fwd_en_reg    <= maccc_pkg::fwd_amount(pwdata[maccc_pkg::KEY_W-1:0],
                                                       maccc_pkg::EN_LEN, direction_reg);
                fwd_ru_reg    <= maccc_pkg::fwd_amount(pwdata[maccc_pkg::KEY_W-1:0],
                                                       maccc_pkg::RU_LEN, direction_reg);
                fwd_sign_reg  <= maccc_pkg::fwd_amount(pwdata[maccc_pkg::KEY_W-1:0],
                                                       maccc_pkg::SIGN_LEN, direction_reg);
                fwd_dig_reg   <= maccc_pkg::fwd_amount(pwdata[maccc_pkg::KEY_W-1:0],
                                                       maccc_pkg::DIG_LEN, direction_reg);
            end
            else begin
                direction_reg <= pwdata[0];
                fwd_en_reg    <= maccc_pkg::fwd_amount(shift_key_reg,
                                                       maccc_pkg::EN_LEN, pwdata[0]);
                fwd_ru_reg    <= maccc_pkg::fwd_amount(shift_key_reg,
                                                       maccc_pkg::RU_LEN, pwdata[0]);
                fwd_sign_reg  <= maccc_pkg::fwd_amount(shift_key_reg,
                                                       maccc_pkg::SIGN_LEN, pwdata[0]);
                fwd_dig_reg   <= maccc_pkg::fwd_amount(shift_key_reg,
                                                       maccc_pkg::DIG_LEN, pwdata[0]);
            end
        end
    end

    always_comb begin
        if (paddr[2] == maccc_pkg::REG_IDX_SHIFT_KEY) begin
            prdata = {{(maccc_pkg::DATA_W-maccc_pkg::KEY_W){1'b0}}, shift_key_reg};
        end
        else begin
            prdata = {{(maccc_pkg::DATA_W-1){1'b0}}, direction_reg};
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control: input register -> result register
    // ------------------------------------------------------------------------
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [maccc_pkg::CHAR_W-1:0] s1_char_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [maccc_pkg::CHAR_W-1:0] char_out_reg;
    logic                        out_free;
    logic                        s1_ready;
    logic                        in_take;
    logic                        has_result;
    logic [maccc_pkg::CHAR_W-1:0] mapped_char;

    // The result register frees up when empty or when its item leaves now;
    // the input register can then always move on, so it only blocks input
    // while the output side holds a stalled result behind it.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || out_free;
    assign in_stall = !s1_ready;
    assign in_take  = in_valid && s1_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_take) begin
            s1_valid_next = 1'b1;
        end
        else if (out_free) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_free) begin
            // drop characters that belong to no alphabet
            out_valid_next = s1_valid_reg && has_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (in_take) begin
            s1_char_reg <= char_in;
        end
        if (out_free) begin
            char_out_reg <= mapped_char;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;

    // ------------------------------------------------------------------------
    // Character datapath: classify, shift the position, map back
    // ------------------------------------------------------------------------
    char_class_t                  cls;
    logic [maccc_pkg::POS_W-1:0]  pos;
    logic [maccc_pkg::POS_W-1:0]  len;
    logic [maccc_pkg::POS_W-1:0]  fwd;
    logic [maccc_pkg::POS_W:0]    pos_sum;
    logic [maccc_pkg::POS_W-1:0]  new_pos;
    logic [maccc_pkg::CHAR_W-1:0] d_en_up;
    logic [maccc_pkg::CHAR_W-1:0] d_en_lo;
    logic [maccc_pkg::CHAR_W-1:0] d_dig;
    logic [maccc_pkg::CHAR_W-1:0] d_ru_up;
    logic [maccc_pkg::CHAR_W-1:0] d_ru_lo;
    logic                         sign_hit;
    logic [maccc_pkg::POS_W-1:0]  sign_pos;

    // Offsets from each range base; a character below the base wraps to a
    // large value and falls out of the range compare.
    assign d_en_up = s1_char_reg - maccc_pkg::EN_UPPER_BASE;
    assign d_en_lo = s1_char_reg - maccc_pkg::EN_LOWER_BASE;
    assign d_dig   = s1_char_reg - maccc_pkg::DIG_BASE;
    assign d_ru_up = s1_char_reg - maccc_pkg::RU_UPPER_BASE;
    assign d_ru_lo = s1_char_reg - maccc_pkg::RU_LOWER_BASE;

    // Parallel compare against the sign table
    always_comb begin
        sign_hit = 1'b0;
        sign_pos = '0;
        for (int i = 0; i < maccc_pkg::SIGN_COUNT; i++) begin
            if (s1_char_reg == maccc_pkg::SIGN_TABLE[i]) begin
                sign_hit = 1'b1;
                sign_pos = maccc_pkg::POS_W'(i);
            end
        end
    end

    always_comb begin
        cls = CLS_NONE;
        pos = '0;
        priority if (s1_char_reg == maccc_pkg::CHAR_SPACE) begin
            cls = CLS_SPACE;
        end
        else if (d_en_up < {10'd0, maccc_pkg::EN_LEN}) begin
            cls = CLS_EN_UPPER;
            pos = d_en_up[maccc_pkg::POS_W-1:0];
        end
        else if (d_en_lo < {10'd0, maccc_pkg::EN_LEN}) begin
            cls = CLS_EN_LOWER;
            pos = d_en_lo[maccc_pkg::POS_W-1:0];
        end
        else if (s1_char_reg == maccc_pkg::RU_UPPER_YO) begin
            cls = CLS_RU_UPPER;
            pos = maccc_pkg::RU_YO_POS;
        end
        else if (d_ru_up < maccc_pkg::RU_SPAN) begin
            cls = CLS_RU_UPPER;
            // letters after YE sit one place further on
            pos = (d_ru_up[maccc_pkg::POS_W-1:0] < maccc_pkg::RU_YO_POS)
                ? d_ru_up[maccc_pkg::POS_W-1:0]
                : d_ru_up[maccc_pkg::POS_W-1:0] + 6'd1;
        end
        else if (s1_char_reg == maccc_pkg::RU_LOWER_YO) begin
            cls = CLS_RU_LOWER;
            pos = maccc_pkg::RU_YO_POS;
        end
        else if (d_ru_lo < maccc_pkg::RU_SPAN) begin
            cls = CLS_RU_LOWER;
            pos = (d_ru_lo[maccc_pkg::POS_W-1:0] < maccc_pkg::RU_YO_POS)
                ? d_ru_lo[maccc_pkg::POS_W-1:0]
                : d_ru_lo[maccc_pkg::POS_W-1:0] + 6'd1;
        end
        else if (sign_hit) begin
            cls = CLS_SIGN;
            pos = sign_pos;
        end
        else if (d_dig < {10'd0, maccc_pkg::DIG_LEN}) begin
            cls = CLS_DIGIT;
            pos = d_dig[maccc_pkg::POS_W-1:0];
        end
        else begin
            cls = CLS_NONE;
        end
    end

    always_comb begin
        unique case (cls)
            CLS_EN_UPPER, CLS_EN_LOWER: begin
                len = maccc_pkg::EN_LEN;
                fwd = fwd_en_reg;
            end
            CLS_RU_UPPER, CLS_RU_LOWER: begin
                len = maccc_pkg::RU_LEN;
                fwd = fwd_ru_reg;
            end
            CLS_SIGN: begin
                len = maccc_pkg::SIGN_LEN;
                fwd = fwd_sign_reg;
            end
            CLS_DIGIT: begin
                len = maccc_pkg::DIG_LEN;
                fwd = fwd_dig_reg;
            end
            default: begin
                len = maccc_pkg::DIG_LEN;
                fwd = '0;
            end
        endcase
    end

    // Both terms are below len, so one conditional subtract wraps the sum
    assign pos_sum = {1'b0, pos} + {1'b0, fwd};
    assign new_pos = (pos_sum >= {1'b0, len})
                   ? maccc_pkg::POS_W'(pos_sum - {1'b0, len})
                   : pos_sum[maccc_pkg::POS_W-1:0];

    assign has_result = (cls != CLS_NONE);

    always_comb begin
        unique case (cls)
            CLS_SPACE: begin
                mapped_char = s1_char_reg;
            end
            CLS_EN_UPPER: begin
                mapped_char = maccc_pkg::EN_UPPER_BASE + {10'd0, new_pos};
            end
            CLS_EN_LOWER: begin
                mapped_char = maccc_pkg::EN_LOWER_BASE + {10'd0, new_pos};
            end
            CLS_RU_UPPER: begin
                if (new_pos < maccc_pkg::RU_YO_POS) begin
                    mapped_char = maccc_pkg::RU_UPPER_BASE + {10'd0, new_pos};
                end
                else if (new_pos == maccc_pkg::RU_YO_POS) begin
                    mapped_char = maccc_pkg::RU_UPPER_YO;
                end
                else begin
                    mapped_char = maccc_pkg::RU_UPPER_BASE + {10'd0, new_pos} - 16'd1;
                end
            end
            CLS_RU_LOWER: begin
                if (new_pos < maccc_pkg::RU_YO_POS) begin
                    mapped_char = maccc_pkg::RU_LOWER_BASE + {10'd0, new_pos};
                end
                else if (new_pos == maccc_pkg::RU_YO_POS) begin
                    mapped_char = maccc_pkg::RU_LOWER_YO;
                end
                else begin
                    mapped_char = maccc_pkg::RU_LOWER_BASE + {10'd0, new_pos} - 16'd1;
                end
            end
            CLS_SIGN: begin
                mapped_char = maccc_pkg::SIGN_TABLE[new_pos[maccc_pkg::SIGN_IDX_W-1:0]];
            end
            CLS_DIGIT: begin
                mapped_char = maccc_pkg::DIG_BASE + {10'd0, new_pos};
            end
            default: begin
                mapped_char = s1_char_reg;
            end
        endcase
    end

endmodule

[rtl/core/maccc_checker.sv]
// ----------------------------------------------------------------------------
// maccc_checker: port-level assertions for the cipher core
// Watches the character channels only and is bound to the top level.
// ----------------------------------------------------------------------------
module maccc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [maccc_pkg::CHAR_W-1:0] char_out
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out))
        else $error("stalled result changed or vanished");

    // Stall the input only behind a blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output side is free");

    // A fresh result follows an input transaction taken into the input register
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without an input transaction");

    // Leave reset with an empty output
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind multi_alphabet_caesar_cipher_core maccc_checker u_maccc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out)
);

[tb/tb_multi_alphabet_caesar_cipher_core.sv]
// ----------------------------------------------------------------------------
// tb_multi_alphabet_caesar_cipher_core: self-checking bench for the cipher core
// Streams UTF-16 code units through the core under a series of key/direction
// settings and checks every output transaction in order against a behavioral
// predictor. It covers random idle gaps on both channels, a long receiver
// hold-off that backs up the pipeline, and a sender pause that drains the
// core mid-phase.
// ----------------------------------------------------------------------------
module tb_multi_alphabet_caesar_cipher_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 6;     // allow for dropped chars still in the core
    localparam int HOLD_CYCLES  = 400;

    localparam logic [maccc_pkg::ADDR_W-1:0] ADDR_SHIFT_KEY =
        {maccc_pkg::REG_IDX_SHIFT_KEY, 2'b00};
    localparam logic [maccc_pkg::ADDR_W-1:0] ADDR_DIRECTION =
        {maccc_pkg::REG_IDX_DIRECTION, 2'b00};

    // Punctuation alphabet in cipher order
    localparam logic [maccc_pkg::CHAR_W-1:0] PUNCT [30] = '{
        16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h005E, 16'h0026,
        16'h002A, 16'h0028, 16'h0029, 16'h002B, 16'h003D, 16'h002D, 16'h005F,
        16'h0027, 16'h003F, 16'h002E, 16'h002C, 16'h007C, 16'h002F, 16'h0060,
        16'h007E, 16'h2116, 16'h003A, 16'h003B, 16'h0040, 16'h005B, 16'h005D,
        16'h007B, 16'h007D
    };

    typedef enum int {
        CLS_SPACE,
        CLS_LATIN_UPPER,
        CLS_LATIN_LOWER,
        CLS_CYR_UPPER,
        CLS_CYR_LOWER,
        CLS_PUNCT,
        CLS_DIGIT
    } char_class_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [maccc_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [maccc_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [maccc_pkg::DATA_W-1:0]   prdata;
    logic                           pready;

    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [maccc_pkg::CHAR_W-1:0]   char_in  = '0;

    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [maccc_pkg::CHAR_W-1:0]   char_out;

    // Predictor copy of the configuration registers
    logic [maccc_pkg::KEY_W-1:0]    key_model = '0;
    logic                           dir_model = maccc_pkg::DIR_ENCRYPT;

    logic [maccc_pkg::CHAR_W-1:0]   plain_chars[$];     // waiting to be offered
    logic [maccc_pkg::CHAR_W-1:0]   expected_chars[$];  // predicted ciphertext, oldest first

    int src_idle_max = 0;
    int rx_idle_max  = 0;
    int src_wait     = 0;
    int rx_wait      = 0;
    int error_count  = 0;
    int cycle_count  = 0;

    logic long_hold_req  = 1'b0;
    int   long_hold_left = 0;

    multi_alphabet_caesar_cipher_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Rotate an alphabet position by the current key, wrapping at len.
    function automatic int rotate_pos(input int pos, input int len);
        int k;
        k = int'(key_model) % len;
        if (dir_model == maccc_pkg::DIR_DECRYPT)
            return (pos + len - k) % len;
        return (pos + k) % len;
    endfunction

    // Cyrillic alphabet position of c: 32 contiguous letters with YO at slot 6.
    function automatic int cyr_pos(input logic [maccc_pkg::CHAR_W-1:0] c,
                                   input logic [maccc_pkg::CHAR_W-1:0] base,
                                   input logic [maccc_pkg::CHAR_W-1:0] yo);
        if (c == yo)
            return 6;
        if (c >= base && c < base + 16'd6)
            return int'(c - base);
        if (c >= base + 16'd6 && c < base + 16'd32)
            return int'(c - base) + 1;
        return -1;
    endfunction

    function automatic logic [maccc_pkg::CHAR_W-1:0] cyr_char(
        input int                           pos,
        input logic [maccc_pkg::CHAR_W-1:0] base,
        input logic [maccc_pkg::CHAR_W-1:0] yo);
        if (pos == 6)
            return yo;
        if (pos < 6)
            return base + maccc_pkg::CHAR_W'(pos);
        return base + maccc_pkg::CHAR_W'(pos - 1);
    endfunction

    // Cipher one code unit; returns 0 when the character produces no output.
    function automatic bit shift_char(input logic [maccc_pkg::CHAR_W-1:0] c,
                                      output logic [maccc_pkg::CHAR_W-1:0] r);
        int p;
        r = c;
        if (c == maccc_pkg::CHAR_SPACE)
            return 1'b1;
        if (c >= 16'h0041 && c <= 16'h005A) begin
            r = 16'h0041 + maccc_pkg::CHAR_W'(rotate_pos(int'(c - 16'h0041), 26));
            return 1'b1;
        end
        if (c >= 16'h0061 && c <= 16'h007A) begin
            r = 16'h0061 + maccc_pkg::CHAR_W'(rotate_pos(int'(c - 16'h0061), 26));
            return 1'b1;
        end
        p = cyr_pos(c, 16'h0410, 16'h0401);
        if (p >= 0) begin
            r = cyr_char(rotate_pos(p, 33), 16'h0410, 16'h0401);
            return 1'b1;
        end
        p = cyr_pos(c, 16'h0430, 16'h0451);
        if (p >= 0) begin
            r = cyr_char(rotate_pos(p, 33), 16'h0430, 16'h0451);
            return 1'b1;
        end
        for (int i = 0; i < 30; i++) begin
            if (PUNCT[i] == c) begin
                r = PUNCT[rotate_pos(i, 30)];
                return 1'b1;
            end
        end
        if (c >= 16'h0030 && c <= 16'h0039) begin
            r = 16'h0030 + maccc_pkg::CHAR_W'(rotate_pos(int'(c - 16'h0030), 10));
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly alphabet members; about one in eight is noise or a near miss.
    function automatic logic [maccc_pkg::CHAR_W-1:0] draw_char();
        char_class_t cls;
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
                0: return maccc_pkg::CHAR_W'($urandom_range(16'h0000, 16'h00FF));
                1: return maccc_pkg::CHAR_W'($urandom_range(16'h03F0, 16'h046F));
                2: return maccc_pkg::CHAR_W'($urandom_range(16'h2100, 16'h212F));
                default: return maccc_pkg::CHAR_W'($urandom());
            endcase
        end
        cls = char_class_t'($urandom_range(CLS_SPACE, CLS_DIGIT));
        case (cls)
            CLS_SPACE:       return maccc_pkg::CHAR_SPACE;
            CLS_LATIN_UPPER: return 16'h0041 + maccc_pkg::CHAR_W'($urandom_range(0, 25));
            CLS_LATIN_LOWER: return 16'h0061 + maccc_pkg::CHAR_W'($urandom_range(0, 25));
            CLS_CYR_UPPER:   return cyr_char($urandom_range(0, 32), 16'h0410, 16'h0401);
            CLS_CYR_LOWER:   return cyr_char($urandom_range(0, 32), 16'h0430, 16'h0451);
            CLS_PUNCT:       return PUNCT[$urandom_range(0, 29)];
            default:         return 16'h0030 + maccc_pkg::CHAR_W'($urandom_range(0, 9));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // Setup cycle, then access cycle; the register loads at the end of the access cycle.
    task automatic apb_write(input logic [maccc_pkg::ADDR_W-1:0] addr,
                             input logic [maccc_pkg::DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Upper data bits are junk on purpose: only the register width must stick.
    task automatic set_cipher(input logic [maccc_pkg::KEY_W-1:0] key, input logic dir);
        logic [maccc_pkg::DATA_W-1:0] key_word;
        logic [maccc_pkg::DATA_W-1:0] dir_word;
        key_word = ($urandom() & ~maccc_pkg::DATA_W'(6'h3F)) | maccc_pkg::DATA_W'(key);
        dir_word = ($urandom() & ~maccc_pkg::DATA_W'(1'b1)) | maccc_pkg::DATA_W'(dir);
        apb_write(ADDR_SHIFT_KEY, key_word);
        apb_write(ADDR_DIRECTION, dir_word);
        key_model = key_word[maccc_pkg::KEY_W-1:0];
        dir_model = dir_word[0];
        @(negedge clk);
    endtask

    // Wait for the core to drain, then let dropped characters flush out.
    task automatic wait_idle();
        while (plain_chars.size() != 0 || in_valid || expected_chars.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [maccc_pkg::KEY_W-1:0] key, input logic dir,
                             input int hits, input int src_max, input int rx_max,
                             input bit drain_midway, input bit hold_rx);
        logic [maccc_pkg::CHAR_W-1:0] c;
        logic [maccc_pkg::CHAR_W-1:0] unused;
        int                           produced;
        produced = 0;
        wait_idle();
        set_cipher(key, dir);
        src_idle_max = src_max;
        rx_idle_max  = rx_max;
        if (hold_rx) begin
            // Receiver backs off while the sender keeps pushing
            @(posedge clk);
            long_hold_req <= 1'b1;
            @(posedge clk);
            long_hold_req <= 1'b0;
            @(negedge clk);
        end
        while (produced < hits) begin
            c = draw_char();
            plain_chars.push_back(c);
            if (shift_char(c, unused))
                produced++;
            if (drain_midway && produced == hits / 2) begin
                // Sender pauses until every pending result is back
                wait_idle();
                drain_midway = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: hold a stalled transaction, otherwise idle or offer next
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        logic [maccc_pkg::CHAR_W-1:0] predicted;
        if (!rst_n) begin
            in_valid <= 1'b0;
            char_in  <= '0;
            src_wait <= 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                if (shift_char(char_in, predicted))
                    expected_chars.push_back(predicted);
            end
            if (!(in_valid && in_stall)) begin
                if (src_wait != 0) begin
                    in_valid <= 1'b0;
                    src_wait <= src_wait - 1;
                end
                else if (plain_chars.size() != 0) begin
                    in_valid <= 1'b1;
                    char_in  <= plain_chars.pop_front();
                    src_wait <= $urandom_range(0, src_idle_max);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted in its own process
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            long_hold_left <= 0;
        else if (long_hold_req)
            long_hold_left <= HOLD_CYCLES;
        else if (long_hold_left != 0)
            long_hold_left <= long_hold_left - 1;
    end

    // ------------------------------------------------------------------------
    // Output monitor: compare each accepted transaction, then draw a stall
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        int                           wait_next;
        logic [maccc_pkg::CHAR_W-1:0] want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_wait   <= 0;
        end
        else begin
            wait_next = (rx_wait != 0) ? rx_wait - 1 : 0;
            if (out_valid && !out_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char_out %h", char_out));
                end
                else begin
                    want = expected_chars.pop_front();
                    if (char_out !== want)
                        report_mismatch($sformatf("char_out %h, expected %h",
                                                  char_out, want));
                end
                wait_next = $urandom_range(0, rx_idle_max);
            end
            rx_wait   <= wait_next;
            out_stall <= (wait_next != 0) || (long_hold_left != 0);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: key 0 encrypt maps every member onto itself
        plain_chars = '{16'h0041, 16'h007A, 16'h0401, 16'h044F, 16'h2116, 16'h0039};
        wait_idle();

        // Directed: key larger than every alphabet size, decrypt, wrap at each alphabet head
        set_cipher(6'd35, maccc_pkg::DIR_DECRYPT);
        plain_chars = '{
            maccc_pkg::CHAR_SPACE, 16'h0000, 16'hFFFF,
            16'h0041, 16'h005A, 16'h0061, 16'h007A,
            16'h0410, 16'h0415, 16'h0401, 16'h0416, 16'h042F,
            16'h0430, 16'h0451, 16'h044F, 16'h0450, 16'h0400,
            16'h0021, 16'h007D, 16'h2116, 16'h0040,
            16'h0030, 16'h0039
        };

        // Random phases: key, direction, results, sender idle, receiver idle, midway drain, receiver hold
        run_phase(6'd0,  maccc_pkg::DIR_ENCRYPT, 100, 11, 11, 1'b0, 1'b0);
        run_phase(6'd63, maccc_pkg::DIR_DECRYPT, 100, 0,  0,  1'b0, 1'b0);
        run_phase(6'd1,  maccc_pkg::DIR_DECRYPT, 100, 11, 0,  1'b1, 1'b0);
        run_phase(6'd32, maccc_pkg::DIR_ENCRYPT, 100, 0,  11, 1'b0, 1'b0);
        run_phase(6'd33, maccc_pkg::DIR_DECRYPT, 100, 5,  5,  1'b0, 1'b0);
        run_phase(6'd26, maccc_pkg::DIR_ENCRYPT, 150, 0,  0,  1'b0, 1'b1);
        run_phase(6'd10, maccc_pkg::DIR_DECRYPT, 100, 11, 11, 1'b0, 1'b0);
        for (int i = 0; i < 3; i++)
            run_phase(maccc_pkg::KEY_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                      34, $urandom_range(0, 1) * 11, $urandom_range(0, 1) * 11,
                      1'b0, 1'b0);

        wait_idle();
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_chars.size()));

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
